### hdl/frc_pkg.sv
// Shared types and constants for the frame row change detector.
package frc_pkg;

   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 1024;
   localparam int QUEUE_DEPTH    = 4;
   localparam int RESULT_DEPTH   = 4;

   localparam int CFG_W         = 11;
   localparam int CSR_INDEX_W   = 1;
   localparam int PIXEL_W       = 32;
   localparam int RGB_W         = 24;
   localparam int ROW_NUM_W     = 10;
   localparam int RSP_TDATA_W   = 16;

   localparam logic [CFG_W-1:0] RESET_FRAME_WIDTH  = 11'd1024;
   localparam logic [CFG_W-1:0] RESET_FRAME_HEIGHT = 11'd768;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_FRAME_WIDTH  = 1'b0,
      REG_FRAME_HEIGHT = 1'b1
   } frc_reg_type;

   typedef struct packed {
      logic [RGB_W-1:0] rgb;
      logic             end_of_row;
      logic             last_row;
   } frc_pix_type;

   typedef struct packed {
      logic                 last_row;
      logic                 row_changed;
      logic [ROW_NUM_W-1:0] row_number;
   } frc_result_type;

endpackage

### hdl/frame_row_change_detector_core.sv
// Pixels pass the input queue and compare stage; row results leave by the result queue.
// Throughput: one pixel per clock unless stalled; one memory read and one write per cycle.
// A row result is issued on the pixel that ends a row; other pixels give no transaction.
// Reset is synchronous; afterward a clearing pass zeroes the frame memory, one entry per
// cycle, over 2**(clog2(MAX_WIDTH)+clog2(MAX_HEIGHT)) entries (1048576 at the defaults).
// During the pass req_tready stays low; configuration writes are taken as usual.
module frame_row_change_detector_core #(
   parameter int MAX_WIDTH  = frc_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = frc_pkg::DEF_MAX_HEIGHT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wen,
   input  logic [frc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [frc_pkg::CFG_W-1:0]        csr_wdata,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // raw_pixel[31:0]
   input  logic [frc_pkg::PIXEL_W-1:0]      req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // row_number[9:0], zeros above
   output logic [frc_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // row_changed
   output logic                             rsp_tuser,
   output logic                             rsp_tlast
);

   import frc_pkg::*;

   localparam int CW     = $clog2(MAX_WIDTH);
   localparam int RW     = $clog2(MAX_HEIGHT);
   localparam int AW     = RW + CW;
   localparam int PIX_W  = $bits(frc_pix_type);
   localparam int ITEM_W = AW + PIX_W;
   localparam int QCW    = $clog2(QUEUE_DEPTH) + 1;
   localparam int OCW    = $clog2(RESULT_DEPTH) + 1;
   localparam int RES_W  = $bits(frc_result_type);

   logic              push;
   logic [AW-1:0]     push_addr;
   frc_pix_type       push_pix;
   logic [ITEM_W-1:0] head_item;
   logic [QCW-1:0]    in_count;
   logic              pop;
   logic              clearing;
   logic [OCW-1:0]    out_count;
   logic              result_push;
   frc_result_type    result;
   logic [RES_W-1:0]  out_bits;
   frc_result_type    out_result;
   logic              rsp_pop;

   frc_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .CW         (CW),
      .RW         (RW)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .space_ok   (in_count < QCW'(QUEUE_DEPTH)),
      .clearing   (clearing),
      .push       (push),
      .push_addr  (push_addr),
      .push_pix   (push_pix)
   );

   frc_fifo #(
      .DATA_W (ITEM_W),
      .DEPTH  (QUEUE_DEPTH)
   ) u_in_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_addr, push_pix}),
      .pop       (pop),
      .pop_data  (head_item),
      .count     (in_count)
   );

   frc_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .CW         (CW),
      .RW         (RW),
      .OUT_CNT_W  (OCW)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (in_count != '0),
      .head_addr   (head_item[ITEM_W-1:PIX_W]),
      .head_pix    (frc_pix_type'(head_item[PIX_W-1:0])),
      .pop         (pop),
      .out_count   (out_count),
      .result_push (result_push),
      .result      (result),
      .clearing    (clearing)
   );

   frc_fifo #(
      .DATA_W (RES_W),
      .DEPTH  (RESULT_DEPTH)
   ) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (result_push),
      .push_data (result),
      .pop       (rsp_pop),
      .pop_data  (out_bits),
      .count     (out_count)
   );

   always_comb begin
      out_result = frc_result_type'(out_bits);
      rsp_tvalid = out_count != '0;
      rsp_pop    = rsp_tvalid && rsp_tready;
      rsp_tdata  = RSP_TDATA_W'(out_result.row_number);
      rsp_tuser  = out_result.row_changed;
      rsp_tlast  = out_result.last_row;
   end

endmodule

### hdl/frc_fifo.sv
// Small register-based first-in first-out queue with an occupancy count.
module frc_fifo #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [DATA_W-1:0]          push_data,
   input  logic                       pop,
   output logic [DATA_W-1:0]          pop_data,
   output logic [$clog2(DEPTH):0]     count
);

   localparam int PW = $clog2(DEPTH);

   logic [DATA_W-1:0] slot_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [PW:0]       count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in  = count_ff + (PW+1)'(push) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = slot_ff[rd_ptr_ff];
   assign count    = count_ff;

endmodule

### hdl/frc_front.sv
// Front end: configuration registers, pixel intake, row and column tracking.
module frc_front #(
   parameter int MAX_WIDTH  = frc_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = frc_pkg::DEF_MAX_HEIGHT,
   parameter int CW         = $clog2(MAX_WIDTH),
   parameter int RW         = $clog2(MAX_HEIGHT)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wen,
   input  logic [frc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [frc_pkg::CFG_W-1:0]         csr_wdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [frc_pkg::PIXEL_W-1:0]       req_tdata,
   input  logic                              space_ok,
   input  logic                              clearing,
   output logic                              push,
   output logic [RW+CW-1:0]                  push_addr,
   output frc_pkg::frc_pix_type              push_pix
);

   import frc_pkg::*;

   logic [CFG_W-1:0] cfg_width_ff, cfg_height_ff;
   logic [CW-1:0]    col_ff, col_in;
   logic [RW-1:0]    row_ff, row_in;
   logic [CW:0]      width_eff, col_next;
   logic [RW:0]      height_eff, row_next;
   logic             end_of_row, last_row;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_width_ff  <= RESET_FRAME_WIDTH;
         cfg_height_ff <= RESET_FRAME_HEIGHT;
      end else if (csr_wen) begin
         unique case (frc_reg_type'(csr_index))
            REG_FRAME_WIDTH:  cfg_width_ff  <= csr_wdata;
            REG_FRAME_HEIGHT: cfg_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (cfg_width_ff == '0) begin
         width_eff = (CW+1)'(1);
      end else if (32'(cfg_width_ff) > 32'(MAX_WIDTH)) begin
         width_eff = (CW+1)'(MAX_WIDTH);
      end else begin
         width_eff = (CW+1)'(cfg_width_ff);
      end
      if (cfg_height_ff == '0) begin
         height_eff = (RW+1)'(1);
      end else if (32'(cfg_height_ff) > 32'(MAX_HEIGHT)) begin
         height_eff = (RW+1)'(MAX_HEIGHT);
      end else begin
         height_eff = (RW+1)'(cfg_height_ff);
      end
   end

   always_comb begin
      req_tready = space_ok && !clearing;
      push       = req_tvalid && req_tready;
      col_next   = {1'b0, col_ff} + (CW+1)'(1);
      row_next   = {1'b0, row_ff} + (RW+1)'(1);
      end_of_row = col_next >= width_eff;
      last_row   = row_next >= height_eff;
      col_in     = col_ff;
      row_in     = row_ff;
      if (push) begin
         if (end_of_row) begin
            col_in = '0;
            row_in = last_row ? '0 : row_next[RW-1:0];
         end else begin
            col_in = col_next[CW-1:0];
         end
      end
      push_addr           = {row_ff, col_ff};
      push_pix.rgb        = req_tdata[RGB_W-1:0];
      push_pix.end_of_row = end_of_row;
      push_pix.last_row   = last_row;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

### hdl/frc_back.sv
// Back end: frame memory with clearing pass, compare and write, row result build.
module frc_back #(
   parameter int MAX_WIDTH  = frc_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = frc_pkg::DEF_MAX_HEIGHT,
   parameter int CW         = $clog2(MAX_WIDTH),
   parameter int RW         = $clog2(MAX_HEIGHT),
   parameter int OUT_CNT_W  = $clog2(frc_pkg::RESULT_DEPTH) + 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    head_valid,
   input  logic [RW+CW-1:0]        head_addr,
   input  frc_pkg::frc_pix_type    head_pix,
   output logic                    pop,
   input  logic [OUT_CNT_W-1:0]    out_count,
   output logic                    result_push,
   output frc_pkg::frc_result_type result,
   output logic                    clearing
);

   import frc_pkg::*;

   localparam int AW    = RW + CW;
   localparam int DEPTH = 1 << AW;

   logic [RGB_W-1:0] store_ff [DEPTH];
   logic [RGB_W-1:0] rd_q_ff;
   logic             clr_active_ff, clr_active_in;
   logic [AW-1:0]    clr_addr_ff, clr_addr_in;
   logic             s1_valid_ff;
   logic [AW-1:0]    s1_addr_ff;
   frc_pix_type      s1_pix_ff;
   logic             fwd_valid_ff, fwd_valid_in;
   logic [RGB_W-1:0] fwd_data_ff;
   logic             differs_ff, differs_in;
   logic [RGB_W-1:0] old_rgb;
   logic             differs_acc;
   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   logic [RGB_W-1:0] wr_data;
   logic [OUT_CNT_W-1:0] committed;

   always_comb begin
      committed = out_count + OUT_CNT_W'(s1_valid_ff && s1_pix_ff.end_of_row);
      pop       = head_valid && !clr_active_ff &&
                  (committed < OUT_CNT_W'(RESULT_DEPTH));
      clearing  = clr_active_ff;

      clr_addr_in   = clr_addr_ff + AW'(1);
      clr_active_in = clr_active_ff && (clr_addr_ff != '1);

      old_rgb     = fwd_valid_ff ? fwd_data_ff : rd_q_ff;
      differs_acc = differs_ff || (old_rgb != s1_pix_ff.rgb);
      differs_in  = differs_ff;
      if (s1_valid_ff) begin
         differs_in = s1_pix_ff.end_of_row ? 1'b0 : differs_acc;
      end
      fwd_valid_in = s1_valid_ff && pop && (s1_addr_ff == head_addr);

      result_push        = s1_valid_ff && s1_pix_ff.end_of_row;
      result.last_row    = s1_pix_ff.last_row;
      result.row_changed = differs_acc;
      result.row_number  = ROW_NUM_W'(s1_addr_ff[AW-1:CW]);

      wr_en   = clr_active_ff || s1_valid_ff;
      wr_addr = clr_active_ff ? clr_addr_ff : s1_addr_ff;
      wr_data = clr_active_ff ? '0 : s1_pix_ff.rgb;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
         s1_valid_ff   <= 1'b0;
         fwd_valid_ff  <= 1'b0;
         differs_ff    <= 1'b0;
      end else begin
         if (clr_active_ff) begin
            clr_active_ff <= clr_active_in;
            clr_addr_ff   <= clr_addr_in;
         end
         s1_valid_ff  <= pop;
         fwd_valid_ff <= fwd_valid_in;
         differs_ff   <= differs_in;
      end
   end

   always_ff @(posedge clock) begin
      fwd_data_ff <= s1_pix_ff.rgb;
      if (pop) begin
         s1_addr_ff <= head_addr;
         s1_pix_ff  <= head_pix;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rd_q_ff <= store_ff[head_addr];
      end
   end

   a_no_pop_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clr_active_ff |-> !pop)
      else $error("pixel taken from queue during clearing pass");

   a_result_room: assert property (@(posedge clock) disable iff (reset)
      result_push |-> (out_count < OUT_CNT_W'(RESULT_DEPTH)))
      else $error("row result pushed into a full result queue");

   a_clear_once: assert property (@(posedge clock) disable iff (reset)
      !clr_active_ff |=> !clr_active_ff)
      else $error("clearing pass restarted without reset");

   a_fwd_has_source: assert property (@(posedge clock) disable iff (reset)
      fwd_valid_ff |-> (s1_valid_ff && $past(s1_valid_ff)))
      else $error("forwarded pixel without a preceding write");

endmodule
